### rtl/core/mig_pkg.sv
package mig_pkg;

  // Default sizes of the image store
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned MaxHeight   = 64;
  localparam int unsigned MaxWidth    = 64;
  localparam int unsigned KernelMax   = 5;
  localparam int unsigned PixelBits   = 32;

  // Fixed widths of the ports
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 7;
  localparam int unsigned ChanW     = 4;
  localparam int unsigned PosW      = 6;
  localparam int unsigned PixInW    = 32;
  localparam int unsigned TapIdxW   = 5;
  localparam int unsigned KDimW     = 4;   // holds 0..15
  localparam int unsigned LimW      = 7;
  localparam int unsigned SmallW    = 3;
  localparam int unsigned CoordW    = 12;  // signed tap coordinate
  localparam int unsigned ExtW      = 16;  // zero-extension for range checks
  localparam int unsigned PixExtW   = 64;

  // Register reset values
  localparam logic [CfgDataW-1:0] HeightRst = 7'd64;
  localparam logic [CfgDataW-1:0] WidthRst  = 7'd64;
  localparam logic [SmallW-1:0]   WinRst    = 3'd3;
  localparam logic [SmallW-1:0]   StepRst   = 3'd1;
  localparam logic [SmallW-1:0]   MarginRst = 3'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_HEIGHT = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_WINDOW_ROWS  = 3'd2,
    REG_WINDOW_COLS  = 3'd3,
    REG_STEP_ROWS    = 3'd4,
    REG_STEP_COLS    = 3'd5,
    REG_MARGIN_ROWS  = 3'd6,
    REG_MARGIN_COLS  = 3'd7
  } reg_idx_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_GATHER = 1'b1
  } op_e;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_e;

  // Effective configuration, window size already clamped
  typedef struct packed {
    logic [KDimW-1:0]  kr;
    logic [KDimW-1:0]  kc;
    logic [LimW-1:0]   hlim;
    logic [LimW-1:0]   wlim;
    logic [SmallW-1:0] step_rows;
    logic [SmallW-1:0] step_cols;
    logic [SmallW-1:0] margin_rows;
    logic [SmallW-1:0] margin_cols;
  } cfg_t;

  // Tap that travels alongside its store read
  typedef struct packed {
    logic               valid;
    logic               in_img;
    logic [TapIdxW-1:0] index;
    logic               last;
  } tap_t;

endpackage

### rtl/core/mig_ram.sv
module mig_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/mig_cfg.sv
module mig_cfg import mig_pkg::*; #(
  parameter int unsigned MAX_HEIGHT = MaxHeight,
  parameter int unsigned MAX_WIDTH  = MaxWidth,
  parameter int unsigned KERNEL_MAX = KernelMax
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  logic [CfgDataW-1:0] height_q, width_q;
  logic [SmallW-1:0]   win_rows_q, win_cols_q, step_rows_q, step_cols_q;
  logic [SmallW-1:0]   margin_rows_q, margin_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q      <= HeightRst;
      width_q       <= WidthRst;
      win_rows_q    <= WinRst;
      win_cols_q    <= WinRst;
      step_rows_q   <= StepRst;
      step_cols_q   <= StepRst;
      margin_rows_q <= MarginRst;
      margin_cols_q <= MarginRst;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_IMAGE_HEIGHT: height_q      <= cfg_data_i;
        REG_IMAGE_WIDTH:  width_q       <= cfg_data_i;
        REG_WINDOW_ROWS:  win_rows_q    <= cfg_data_i[SmallW-1:0];
        REG_WINDOW_COLS:  win_cols_q    <= cfg_data_i[SmallW-1:0];
        REG_STEP_ROWS:    step_rows_q   <= cfg_data_i[SmallW-1:0];
        REG_STEP_COLS:    step_cols_q   <= cfg_data_i[SmallW-1:0];
        REG_MARGIN_ROWS:  margin_rows_q <= cfg_data_i[SmallW-1:0];
        REG_MARGIN_COLS:  margin_cols_q <= cfg_data_i[SmallW-1:0];
      endcase
    end
  end

  function automatic logic [KDimW-1:0] clamp_win(input logic [SmallW-1:0] v);
    logic [KDimW-1:0] vx;
    vx = KDimW'(v);
    if (vx == '0) begin
      return KDimW'(1);
    end else if (vx > KDimW'(KERNEL_MAX)) begin
      return KDimW'(KERNEL_MAX);
    end
    return vx;
  endfunction

  always_comb begin
    cfg_o.kr = clamp_win(win_rows_q);
    cfg_o.kc = clamp_win(win_cols_q);
    // image limits never exceed the store
    cfg_o.hlim = (ExtW'(height_q) > ExtW'(MAX_HEIGHT)) ? LimW'(MAX_HEIGHT) : height_q;
    cfg_o.wlim = (ExtW'(width_q) > ExtW'(MAX_WIDTH)) ? LimW'(MAX_WIDTH) : width_q;
    cfg_o.step_rows   = step_rows_q;
    cfg_o.step_cols   = step_cols_q;
    cfg_o.margin_rows = margin_rows_q;
    cfg_o.margin_cols = margin_cols_q;
  end

endmodule

### rtl/core/mig_seq.sv
module mig_seq import mig_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannels,
  parameter int unsigned MAX_HEIGHT   = MaxHeight,
  parameter int unsigned MAX_WIDTH    = MaxWidth,
  localparam int unsigned ChW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
  localparam int unsigned RowW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
  localparam int unsigned ColW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned AddrW  = ChW + RowW + ColW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             operation_i,
  input  logic [ChanW-1:0] channel_i,
  input  logic [PosW-1:0]  pos_row_i,
  input  logic [PosW-1:0]  pos_col_i,
  input  cfg_t             cfg_i,
  output logic             busy,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  output tap_t             tap_o
);

  seq_state_e state_q, state_d;

  logic signed [CoordW-1:0] h0_q, w0_q, h, w;
  logic [ChW-1:0]           ch_q;
  logic                     ch_ok_q;
  logic [KDimW-1:0]         i_q, j_q;
  logic [TapIdxW-1:0]       k_q;
  tap_t                     tap_q;
  logic [ExtW-1:0]          ch_x;
  logic                     go, last_tap, in_img;

  assign ch_x     = ExtW'(channel_i);
  assign last_tap = (i_q == cfg_i.kr - KDimW'(1)) && (j_q == cfg_i.kc - KDimW'(1));
  // the next request may enter while the final tap is read
  assign go       = start && !busy && (op_e'(operation_i) == OP_GATHER);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: if (go) state_d = SEQ_RUN;
      SEQ_RUN:  if (last_tap && !go) state_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    rd_en_o = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        busy    = 1'b0;
        rd_en_o = 1'b0;
      end
      SEQ_RUN: begin
        busy    = !last_tap;
        rd_en_o = 1'b1;
      end
    endcase
  end

  assign h = h0_q + $signed(CoordW'(i_q));
  assign w = w0_q + $signed(CoordW'(j_q));

  assign in_img = ch_ok_q && !h[CoordW-1] && !w[CoordW-1]
                  && (h < $signed(CoordW'(cfg_i.hlim)))
                  && (w < $signed(CoordW'(cfg_i.wlim)));

  assign rd_addr_o = {ch_q, h[RowW-1:0], w[ColW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      tap_q   <= '0;
    end else begin
      state_q      <= state_d;
      tap_q.valid  <= (state_q == SEQ_RUN);
      tap_q.in_img <= in_img;
      tap_q.index  <= k_q;
      tap_q.last   <= last_tap && (state_q == SEQ_RUN);
      if (go) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end else if (state_q == SEQ_RUN) begin
        k_q <= k_q + TapIdxW'(1);   // wraps like the 5-bit index
        if (j_q == cfg_i.kc - KDimW'(1)) begin
          j_q <= '0;
          i_q <= i_q + KDimW'(1);
        end else begin
          j_q <= j_q + KDimW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      h0_q    <= $signed(CoordW'(pos_row_i) * CoordW'(cfg_i.step_rows))
                 - $signed(CoordW'(cfg_i.margin_rows));
      w0_q    <= $signed(CoordW'(pos_col_i) * CoordW'(cfg_i.step_cols))
                 - $signed(CoordW'(cfg_i.margin_cols));
      ch_q    <= ch_x[ChW-1:0];
      ch_ok_q <= ch_x < ExtW'(MAX_CHANNELS);
    end
  end

  assign tap_o = tap_q;

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN && last_tap && !go) |=> (state_q == SEQ_IDLE))
    else $error("sequencer ran past the final tap");

  a_go_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> (state_q == SEQ_RUN && i_q == '0 && j_q == '0 && k_q == '0))
    else $error("gather request did not restart the window");

  a_tap_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_q.valid |-> $past(rd_en_o))
    else $error("tap strobe without a store read");

  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_q.last |-> tap_q.valid)
    else $error("last flag outside a tap");

endmodule

### rtl/core/masked_im2col_gather.sv
// Channel  Direction  Handshake                 Payload
// request  in         start && !busy            operation_i channel_i pos_row_i pos_col_i pixel_in_i
// result   out        tap_valid_o, one cycle    tap_value_o tap_inside_o tap_index_o tap_last_o
// config   in         cfg_we_i                  cfg_idx_i cfg_data_i
//
// A pixel write produces no result; busy stays low.
// A gather makes one store read per tap on the
// single read port; taps appear in the cycle after their read, back to back.
// The next request is taken in the cycle the final tap is read.
// Reset clears the configuration to its defaults; the store is not cleared.
// Results cannot be held off: each tap is shown for exactly one cycle.
module masked_im2col_gather import mig_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannels,
  parameter int unsigned MAX_HEIGHT   = MaxHeight,
  parameter int unsigned MAX_WIDTH    = MaxWidth,
  parameter int unsigned KERNEL_MAX   = KernelMax,
  parameter int unsigned PIXEL_BITS   = PixelBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                operation_i,
  input  logic [ChanW-1:0]    channel_i,
  input  logic [PosW-1:0]     pos_row_i,
  input  logic [PosW-1:0]     pos_col_i,
  input  logic [PixInW-1:0]   pixel_in_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                tap_valid_o,
  output logic [PixInW-1:0]   tap_value_o,
  output logic                tap_inside_o,
  output logic [TapIdxW-1:0]  tap_index_o,
  output logic                tap_last_o
);

  localparam int unsigned ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned AddrW = ChW + RowW + ColW;
  localparam int unsigned Depth = 2 ** AddrW;

  cfg_t                  cfg;
  tap_t                  tap;
  logic                  rd_en, wr_en;
  logic [AddrW-1:0]      rd_addr, wr_addr;
  logic [PIXEL_BITS-1:0] wr_data, rd_data;
  logic [ExtW-1:0]       ch_x, row_x, col_x;
  logic [PixExtW-1:0]    pix_x, rd_x;

  mig_cfg #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .KERNEL_MAX (KERNEL_MAX)
  ) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  mig_seq #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .start,
    .operation_i,
    .channel_i,
    .pos_row_i,
    .pos_col_i,
    .cfg_i     (cfg),
    .busy,
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .tap_o     (tap)
  );

  // pixel writes: dropped when outside the store
  assign ch_x    = ExtW'(channel_i);
  assign row_x   = ExtW'(pos_row_i);
  assign col_x   = ExtW'(pos_col_i);
  assign pix_x   = PixExtW'(pixel_in_i);
  assign wr_data = pix_x[PIXEL_BITS-1:0];
  assign wr_addr = {ch_x[ChW-1:0], row_x[RowW-1:0], col_x[ColW-1:0]};
  assign wr_en   = start && !busy && (op_e'(operation_i) == OP_WRITE)
                   && (ch_x < ExtW'(MAX_CHANNELS))
                   && (row_x < ExtW'(MAX_HEIGHT))
                   && (col_x < ExtW'(MAX_WIDTH));

  mig_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (Depth)
  ) u_store (
    .clk_i,
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_x         = PixExtW'(rd_data);
  assign tap_valid_o  = tap.valid;
  assign tap_inside_o = tap.in_img;
  assign tap_index_o  = tap.index;
  assign tap_last_o   = tap.last;
  assign tap_value_o  = tap.in_img ? rd_x[PixInW-1:0] : '0;

endmodule
